// ===== rtl/core/min_tracking_stack_unit_defines.svh =====
// Assertion macros used by the checker file of the min tracking stack.
`ifndef MIN_TRACKING_STACK_UNIT_DEFINES_SVH
`define MIN_TRACKING_STACK_UNIT_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define MTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

   localparam int DATA_W  = 32;
   localparam int DEPTH_W = 7;

   // operation codes carried in the mode field
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one stack entry: the pushed value and the running minimum at push time
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] run_min;
   } entry_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic [DEPTH_W-1:0]       depth_now;
      logic                     is_empty;
      status_type               status;
   } rsp_type;

endpackage

// ===== rtl/core/mts_if.sv =====
interface mts_req_if import mts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output mode, output push_value, input ready);
   modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic signed [DATA_W-1:0] min_value;
   logic [DEPTH_W-1:0]       depth_now;
   logic                     is_empty;
   logic [1:0]               status;

   modport source (output valid, output top_value, output min_value, output depth_now,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input top_value, input min_value, input depth_now,
                   input is_empty, input status, output ready);
endinterface

// ===== rtl/core/mts_store.sv =====
module mts_store import mts_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry
);

   logic signed [DATA_W-1:0] value_mem   [STACK_DEPTH];
   logic signed [DATA_W-1:0] run_min_mem [STACK_DEPTH];
   entry_type                rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr]   <= wr_entry.value;
         run_min_mem[wr_addr] <= wr_entry.run_min;
      end
      if (rd_en) begin
         rd_entry_ff.value   <= value_mem[rd_addr];
         rd_entry_ff.run_min <= run_min_mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
module mts_ctrl import mts_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     req_ready,
   input  logic                     buf_free,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output entry_type                wr_entry,
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  entry_type                rd_entry,
   output logic                     res_valid,
   output rsp_type                  res
);

   typedef enum logic {ST_IDLE, ST_POP_WAIT} state_type;

   state_type     state_ff,  state_in;
   logic [CW-1:0] count_ff,  count_in;
   entry_type     top_ff,    top_in;
   logic          accept;
   logic          is_full;
   logic          is_none;
   logic [CW-1:0] below_ptr;
   entry_type     push_entry;

   function automatic rsp_type make_rsp(logic [CW-1:0] cnt, entry_type top, status_type st);
      rsp_type r;
      r.depth_now = DEPTH_W'(cnt);
      r.is_empty  = (cnt == '0);
      r.top_value = r.is_empty ? '0 : top.value;
      r.min_value = r.is_empty ? '0 : top.run_min;
      r.status    = st;
      return r;
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && buf_free;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(STACK_DEPTH));
   assign is_none   = (count_ff == '0);
   assign below_ptr = count_ff - CW'(2);

   // new entry keeps the smaller of the value and the running minimum below it
   always_comb begin
      push_entry.value   = req_push_value;
      push_entry.run_min = (!is_none && (top_ff.run_min < req_push_value)) ?
                           top_ff.run_min : req_push_value;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_entry  = push_entry;
      rd_en     = 1'b0;
      rd_addr   = below_ptr[AW-1:0];
      res_valid = 1'b0;
      res       = make_rsp(count_ff, top_ff, STATUS_DONE);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == OP_PUSH) begin
                  res_valid = 1'b1;
                  if (is_full) begin
                     res = make_rsp(count_ff, top_ff, STATUS_FULL);
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                     top_in   = push_entry;
                     res      = make_rsp(count_in, push_entry, STATUS_DONE);
                  end
               end else begin
                  if (is_none) begin
                     res_valid = 1'b1;
                     res       = make_rsp(count_ff, top_ff, STATUS_EMPTY);
                  end else if (count_ff == CW'(1)) begin
                     res_valid = 1'b1;
                     count_in  = '0;
                     res       = make_rsp(count_in, top_ff, STATUS_DONE);
                  end else begin
                     // fetch the entry below the top; it arrives next cycle
                     rd_en    = 1'b1;
                     count_in = count_ff - CW'(1);
                     state_in = ST_POP_WAIT;
                  end
               end
            end
         end
         ST_POP_WAIT: begin
            top_in    = rd_entry;
            res_valid = 1'b1;
            res       = make_rsp(count_ff, rd_entry, STATUS_DONE);
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      top_ff <= top_in;
   end

endmodule

// ===== rtl/core/mts_outbuf.sv =====
module mts_outbuf import mts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_rsp,
   output logic    free,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);

   logic    out_valid_ff;
   rsp_type out_rsp_ff;
   logic    skid_valid_ff;
   rsp_type skid_rsp_ff;
   logic    out_open;

   assign out_open  = !out_valid_ff || out_ready;
   assign free      = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_open) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= in_valid;
         end else begin
            out_valid_ff  <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
      if (out_open) begin
         out_rsp_ff <= skid_valid_ff ? skid_rsp_ff : in_rsp;
      end
      if (in_valid && (skid_valid_ff || !out_open)) begin
         skid_rsp_ff <= in_rsp;
      end
   end

endmodule

// ===== rtl/core/min_tracking_stack_unit.sv =====
// Min tracking stack: a LIFO of up to STACK_DEPTH signed 32-bit values that
// also reports the minimum of all held values. Each request transfer is a
// push (mode 0) or a pop (mode 1), and each yields exactly one response
// transfer carrying the new top, the minimum, the depth, an empty flag and
// a status (done, push rejected full, pop rejected empty; a rejected
// operation leaves the stack unchanged). Top and minimum read 0 when empty.
// Every entry stores its value and the running minimum at push time in a
// synchronous store; the current top is also held in a register. A push,
// a rejected operation and a pop that empties the stack complete in the
// idle state; a pop that leaves entries also passes a pop-wait state,
// since the new top comes from the store's registered read port. The
// response is registered in a two-entry output buffer, which lets the
// next request be taken while a response waits on rsp_chan.ready.
// Reset is synchronous and empties the stack without touching the store.
module min_tracking_stack_unit import mts_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   mts_req_if.sink   req_chan,
   mts_rsp_if.source rsp_chan
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_entry;
   logic          buf_free;
   logic          res_valid;
   rsp_type       res;
   rsp_type       out_rsp;

   // sequence push and pop, keep the depth and the cached top
   mts_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_mode       (req_chan.mode),
      .req_push_value (req_chan.push_value),
      .req_ready      (req_chan.ready),
      .buf_free       (buf_free),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_entry       (wr_entry),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_entry       (rd_entry),
      .res_valid      (res_valid),
      .res            (res)
   );

   // value and running minimum per entry
   mts_store #(.STACK_DEPTH(STACK_DEPTH)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // hold responses until the sink takes them
   mts_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_rsp    (res),
      .free      (buf_free),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_rsp   (out_rsp)
   );

   assign rsp_chan.top_value = out_rsp.top_value;
   assign rsp_chan.min_value = out_rsp.min_value;
   assign rsp_chan.depth_now = out_rsp.depth_now;
   assign rsp_chan.is_empty  = out_rsp.is_empty;
   assign rsp_chan.status    = out_rsp.status;

endmodule

// ===== rtl/core/mts_checker.sv =====
`include "min_tracking_stack_unit_defines.svh"

module mts_checker import mts_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_top_value,
   input logic signed [DATA_W-1:0] rsp_min_value,
   input logic [DEPTH_W-1:0]       rsp_depth_now,
   input logic                     rsp_is_empty,
   input logic [1:0]               rsp_status
);

   `MTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_top_value) && $stable(rsp_min_value) && $stable(rsp_depth_now) && $stable(rsp_status), "stalled response changed")
   `MTS_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid && rsp_is_empty, (rsp_depth_now == '0) && (rsp_top_value == '0) && (rsp_min_value == '0), "empty response not zero")
   `MTS_ASSERT_IMPL(a_pop_empty, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_is_empty, "pop rejected on a non-empty stack")
   `MTS_ASSERT_IMPL(a_push_full, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), !rsp_is_empty && (rsp_depth_now == DEPTH_W'(STACK_DEPTH)), "push rejected below full depth")
   `MTS_ASSERT_IMPL(a_min_le_top, clock, reset, rsp_valid && !rsp_is_empty, rsp_min_value <= rsp_top_value, "minimum above top value")

endmodule

bind min_tracking_stack_unit mts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mts_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_top_value (rsp_chan.top_value),
   .rsp_min_value (rsp_chan.min_value),
   .rsp_depth_now (rsp_chan.depth_now),
   .rsp_is_empty  (rsp_chan.is_empty),
   .rsp_status    (rsp_chan.status)
);
